[rtl/core/sobel_edge_magnitude_3x3_macros.svh]
// Assertion helpers for the edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SEM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/core/sem_pkg.sv]
`default_nettype none
package sem_pkg;
  localparam int MaxWidth = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int CntW = 11;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  localparam logic [0:0] CfgWidth = 1'b0;
  localparam logic [0:0] CfgHeight = 1'b1;

  typedef logic [23:0] pix_t;

  // One window job handed from the front to the back.
  typedef struct packed {
    pix_t l0, l1, l2;
    pix_t m0, m1, m2;
    pix_t r0, r1, r2;
    logic eof;
    logic lob;
  } job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic eof;
    logic lob;
  } res_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_DONE
  } sq_state_t;
endpackage
`default_nettype wire

[rtl/core/sem_front.sv]
`default_nettype none
// Front: line stores, window and frame counters; forms at most two jobs per pixel.
module sem_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [10:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_kind,
  input  wire sem_pkg::pix_t          in_pix,
  output logic                        job_valid,
  output sem_pkg::job_t               job,
  input  wire logic                   job_ready
);
  logic [10:0] fw_r, fh_r;
  logic [sem_pkg::ColW-1:0] col_r;
  logic [sem_pkg::CntW-1:0] row_r;
  sem_pkg::pix_t win_r [6];
  logic [47:0] mem [sem_pkg::MaxWidth];
  logic [47:0] line_q;

  // Phase 0 reads the line store, phase 1 computes and writes.
  logic ph_r;
  logic kind_r;
  sem_pkg::pix_t pix_r;
  logic second_r;

  logic [10:0] w, h;
  logic last, lastc;
  sem_pkg::pix_t c0, c1, c2;
  logic has_first;

  always_comb begin
    w = (fw_r == 11'd0) ? 11'd1
        : (fw_r > 11'(sem_pkg::MaxWidth) ? 11'(sem_pkg::MaxWidth) : fw_r);
    h = (fh_r == 11'd0) ? 11'd1
        : (fh_r > 11'(sem_pkg::MaxHeight) ? 11'(sem_pkg::MaxHeight) : fh_r);
    last = (11'(col_r) + 11'd1) >= w;
    c2 = (row_r < h && !kind_r) ? pix_r : '0;
    c1 = (row_r >= 11'd1) ? line_q[23:0] : '0;
    c0 = (row_r >= 11'd2) ? line_q[47:24] : '0;
    has_first = (col_r != '0);
    lastc = last;
  end

  assign in_ready = !ph_r && !cfg_valid;
  // A register write waits until the pixel in hand is finished.
  assign cfg_ready = !ph_r;

  // Job selection: first job is the interior pixel, second the row end.
  always_comb begin
    job = '0;
    job_valid = 1'b0;
    if (ph_r && row_r >= 11'd1) begin
      if (has_first && !second_r) begin
        job_valid = 1'b1;
        job.l0 = win_r[0]; job.l1 = win_r[1]; job.l2 = win_r[2];
        job.m0 = win_r[3]; job.m1 = win_r[4]; job.m2 = win_r[5];
        job.r0 = c0; job.r1 = c1; job.r2 = c2;
        job.lob = !lastc;
      end else if (lastc) begin
        job_valid = 1'b1;
        job.l0 = win_r[3]; job.l1 = win_r[4]; job.l2 = win_r[5];
        job.m0 = c0; job.m1 = c1; job.m2 = c2;
        job.eof = (row_r >= h);
        job.lob = 1'b1;
      end
    end
  end

  logic finish;
  assign finish = ph_r && (!job_valid || (job_ready && job.lob));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      line_q <= mem[col_r];
      kind_r <= in_kind;
      pix_r <= in_pix;
    end
    if (finish) mem[col_r] <= {line_q[23:0], c2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 11'd1024; fh_r <= 11'd1024;
      col_r <= '0; row_r <= '0; ph_r <= 1'b0; second_r <= 1'b0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (cfg_valid && !ph_r) begin
      if (cfg_index == sem_pkg::CfgWidth) fw_r <= cfg_data;
      else fh_r <= cfg_data;
      col_r <= '0; row_r <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (in_valid && in_ready) begin
      ph_r <= 1'b1;
    end else if (ph_r) begin
      if (job_valid && job_ready && !job.lob) second_r <= 1'b1;
      if (finish) begin
        ph_r <= 1'b0;
        second_r <= 1'b0;
        if (lastc) begin
          for (int i = 0; i < 6; i++) win_r[i] <= '0;
          col_r <= '0;
          row_r <= (row_r >= h) ? '0 : row_r + 11'd1;
        end else begin
          win_r[0] <= has_first ? win_r[3] : '0;
          win_r[1] <= has_first ? win_r[4] : '0;
          win_r[2] <= has_first ? win_r[5] : '0;
          win_r[3] <= c0; win_r[4] <= c1; win_r[5] <= c2;
          col_r <= col_r + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/sem_queue.sv]
`default_nettype none
// Short job queue between front and back.
module sem_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire sem_pkg::job_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output sem_pkg::job_t      rd_data
);
  sem_pkg::job_t q_r [sem_pkg::QDepth];
  logic [sem_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [sem_pkg::QPtrW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (sem_pkg::QPtrW+1)'(sem_pkg::QDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_data = q_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) if (wr) q_r[wp_r] <= wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end
endmodule
`default_nettype wire

[rtl/core/sem_back.sv]
`default_nettype none
// Back: gradient, squared sum, and bit-serial root over eight steps per job.
module sem_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire sem_pkg::job_t job,
  output logic               res_valid,
  input  wire logic          res_ready,
  output sem_pkg::res_t      res
);
  sem_pkg::sq_state_t st_r, st_nxt;
  logic [21:0] s_r [3];
  logic [7:0] n_r [3];
  logic [7:0] bit_r;
  logic eof_r, lob_r;

  function automatic logic [21:0] sumsq(sem_pkg::job_t j, int sh);
    logic signed [11:0] gx, gy;
    logic signed [11:0] a0, a1, a2, b0, b1, b2, t1, t3;
    logic [23:0] px, py;
    a0 = 12'(j.l0[sh+:8]); a1 = 12'(j.l1[sh+:8]); a2 = 12'(j.l2[sh+:8]);
    b0 = 12'(j.r0[sh+:8]); b1 = 12'(j.r1[sh+:8]); b2 = 12'(j.r2[sh+:8]);
    t1 = 12'(j.m0[sh+:8]); t3 = 12'(j.m2[sh+:8]);
    gx = b0 - a0 + 12'(2) * (b1 - a1) + b2 - a2;
    gy = a2 + b2 + 12'(2) * t3 - a0 - b0 - 12'(2) * t1;
    px = 24'(gx) * 24'(gx);
    py = 24'(gy) * 24'(gy);
    return 22'(px + py);
  endfunction

  function automatic logic [7:0] finish_root(logic [21:0] s, logic [7:0] n);
    logic [16:0] nn;
    nn = 17'(n) * 17'(n) + 17'(n);
    if (s >= 22'd65025) return 8'd255;
    if (22'(nn) < s) return n + 8'd1;
    return n;
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sem_pkg::SQ_IDLE: if (job_valid) st_nxt = sem_pkg::SQ_RUN;
      sem_pkg::SQ_RUN:  if (bit_r == 8'd1) st_nxt = sem_pkg::SQ_DONE;
      sem_pkg::SQ_DONE: if (res_ready) st_nxt = sem_pkg::SQ_IDLE;
      default: st_nxt = sem_pkg::SQ_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == sem_pkg::SQ_IDLE);
    res_valid = (st_r == sem_pkg::SQ_DONE);
    res.red = finish_root(s_r[0], n_r[0]);
    res.green = finish_root(s_r[1], n_r[1]);
    res.blue = finish_root(s_r[2], n_r[2]);
    res.eof = eof_r;
    res.lob = lob_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= sem_pkg::SQ_IDLE;
    else st_r <= st_nxt;
  end

  // One root bit per cycle per channel, most significant first.
  always_ff @(posedge clk) begin
    if (st_r == sem_pkg::SQ_IDLE && job_valid) begin
      s_r[0] <= sumsq(job, 16); s_r[1] <= sumsq(job, 8); s_r[2] <= sumsq(job, 0);
      for (int i = 0; i < 3; i++) n_r[i] <= '0;
      bit_r <= 8'd128;
      eof_r <= job.eof; lob_r <= job.lob;
    end else if (st_r == sem_pkg::SQ_RUN) begin
      for (int i = 0; i < 3; i++)
        if (22'(17'(n_r[i] | bit_r) * 17'(n_r[i] | bit_r)) <= s_r[i]) n_r[i] <= n_r[i] | bit_r;
      bit_r <= bit_r >> 1;
    end
  end
endmodule
`default_nettype wire

[rtl/core/sem_outq.sv]
`default_nettype none
// Two-entry result skid queue facing the output port.
module sem_outq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire sem_pkg::res_t wr_data,
  output logic               empty,
  input  wire logic          pop,
  output sem_pkg::res_t      rd_data
);
  sem_pkg::res_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rd_data = q_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = pop && !empty;

  always_ff @(posedge clk) if (wr) q_r[wp_r] <= wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + (wr ? 2'd1 : 2'd0) - (rd ? 2'd1 : 2'd0);
    end
  end
endmodule
`default_nettype wire

[rtl/core/sobel_edge_magnitude_3x3.sv]
`default_nettype none
// Channel  Handshake            Payload
// input    push / full          in_kind, in_red_in, in_green_in, in_blue_in
// result   pop / empty          out_red_out .. out_blue_out, out_end_of_frame, out_last_of_burst
// config   cfg_valid/cfg_ready  cfg_index, cfg_data
// A pixel passes the front's read phase (line store read), then its write phase (write with
// its job), which lasts until both jobs are taken when it hands two jobs to the queue, as at a
// row end; the back runs the eight-step root iteration per job and takes no new job until its last result is taken.
// Reset (rst_n low, synchronous) restores width and height 1024 and clears counters.
// Either side may stall; the job queue and the result queue absorb the difference.
// A register write waits while the front holds a pixel.
module sobel_edge_magnitude_3x3 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_end_of_frame,
  output logic             out_last_of_burst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  logic in_ready, fj_valid, fj_ready, bj_valid, bj_ready, r_valid, r_ready;
  sem_pkg::job_t fj, bj;
  sem_pkg::res_t r, ro;

  assign full = !in_ready;

  sem_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(push), .in_ready(in_ready), .in_kind(in_kind),
    .in_pix({in_red_in, in_green_in, in_blue_in}), .job_valid(fj_valid), .job(fj),
    .job_ready(fj_ready)
  );
  sem_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );
  sem_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .res_valid(r_valid), .res_ready(r_ready), .res(r)
  );
  sem_outq u_outq (
    .clk(clk), .rst_n(rst_n), .wr_valid(r_valid), .wr_ready(r_ready), .wr_data(r),
    .empty(empty), .pop(pop), .rd_data(ro)
  );

  assign out_red_out = ro.red;
  assign out_green_out = ro.green;
  assign out_blue_out = ro.blue;
  assign out_end_of_frame = ro.eof;
  assign out_last_of_burst = ro.lob;

`include "sobel_edge_magnitude_3x3_macros.svh"
  `SEM_ASSERT_IMP(a_eof_is_last, !empty && out_end_of_frame, out_last_of_burst, "eof without last")
  `SEM_ASSERT_NEXT(a_accept_busy, push && !full && !cfg_valid, full, "front took two pixels")
  `SEM_ASSERT_NEXT(a_job_hold, fj_valid && !fj_ready, fj_valid, "job dropped while queue full")
endmodule
`default_nettype wire
